// ----- src/hfrl2_pkg.sv -----
package hfrl2_pkg;

   localparam int ACC_FRAC_BITS = 20;
   // squares carry 48 fraction bits before truncation to the sum format
   localparam int SQ_SHIFT = 48 - ACC_FRAC_BITS;
   localparam int SQ_W = SQ_SHIFT + 64;

   localparam int HALF_MAG_W = 40;
   localparam int MAG_W = 41;
   localparam int LO_W = 24;
   localparam int HI_W = MAG_W - LO_W;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [31:0] ONE_Q8_24 = 32'h0100_0000;
   localparam logic [4:0] EXP_SPECIAL = 5'h1f;

   typedef enum logic [1:0] {
      KIND_ADD,
      KIND_SKIP,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      logic [15:0] reference_half;
      logic [15:0] approx_half;
      logic        last_pair;
   } req_type;

   typedef struct packed {
      logic [31:0] relative_error;
      logic        within_threshold;
      logic        saturated;
   } rsp_type;

   typedef struct packed {
      kind_type           kind;
      logic               last;
      logic [MAG_W-1:0]   diff_mag;
      logic [MAG_W-1:0]   ref_mag;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   // exact magnitude of a finite half, in units of 2^-24
   function automatic logic [HALF_MAG_W-1:0] half_mag(input logic [15:0] h);
      logic [4:0] e;
      logic [HALF_MAG_W-1:0] m;
      e = h[14:10];
      m = {{(HALF_MAG_W-11){1'b0}}, 1'b1, h[9:0]};
      if (e == 5'd0) begin
         return {{(HALF_MAG_W-10){1'b0}}, h[9:0]};
      end
      return m << (e - 5'd1);
   endfunction

endpackage

// ----- src/hfrl2_front.sv -----
module hfrl2_front (
   input  logic              clock,
   input  logic              reset,
   input  hfrl2_pkg::req_type req_payload,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              pop,
   output hfrl2_pkg::head_type head
);

   localparam int PTR_W = $clog2(hfrl2_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(hfrl2_pkg::QUEUE_DEPTH + 1);
   localparam int SW = hfrl2_pkg::MAG_W + 1;

   hfrl2_pkg::entry_type entries_ff [hfrl2_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   logic [hfrl2_pkg::HALF_MAG_W-1:0] ref_m, app_m;
   logic signed [SW-1:0] ref_s, app_s, diff_s;
   logic ref_finite, app_finite, push;
   hfrl2_pkg::entry_type new_entry;

   always_comb begin
      ref_m = hfrl2_pkg::half_mag(req_payload.reference_half);
      app_m = hfrl2_pkg::half_mag(req_payload.approx_half);
      ref_finite = req_payload.reference_half[14:10] != hfrl2_pkg::EXP_SPECIAL;
      app_finite = req_payload.approx_half[14:10] != hfrl2_pkg::EXP_SPECIAL;
      ref_s = req_payload.reference_half[15] ? -$signed({2'b00, ref_m})
                                             : $signed({2'b00, ref_m});
      app_s = req_payload.approx_half[15] ? -$signed({2'b00, app_m})
                                          : $signed({2'b00, app_m});
      diff_s = app_s - ref_s;
      new_entry.last = req_payload.last_pair;
      new_entry.ref_mag = {1'b0, ref_m};
      new_entry.diff_mag = diff_s[SW-1] ? hfrl2_pkg::MAG_W'(-diff_s)
                                        : hfrl2_pkg::MAG_W'(diff_s);
      if (!ref_finite) begin
         new_entry.kind = hfrl2_pkg::KIND_SKIP;
      end else if (!app_finite) begin
         new_entry.kind = hfrl2_pkg::KIND_BAD;
      end else begin
         new_entry.kind = hfrl2_pkg::KIND_ADD;
      end
   end

   assign req_stall = count_ff == CNT_W'(hfrl2_pkg::QUEUE_DEPTH);
   assign push = req_valid && !req_stall;
   assign head.valid = count_ff != '0;
   assign head.entry = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(hfrl2_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(hfrl2_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- src/hfrl2_back.sv -----
module hfrl2_back (
   input  logic               clock,
   input  logic               reset,
   input  hfrl2_pkg::head_type head,
   output logic               pop,
   input  logic [31:0]        threshold,
   output hfrl2_pkg::rsp_type rsp_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall
);

   localparam int HI_W = hfrl2_pkg::HI_W;
   localparam int LO_W = hfrl2_pkg::LO_W;
   localparam int HH_W = 2 * HI_W;
   localparam int HL_W = HI_W + LO_W;
   localparam int LL_W = 2 * LO_W;
   localparam int SQ_W = hfrl2_pkg::SQ_W;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_ADD, S_ACC, S_FIN, S_DIV, S_SQRT, S_OUT
   } state_type;

   state_type state_ff;
   hfrl2_pkg::entry_type cur_ff;
   logic [HH_W-1:0] dhh_ff, ahh_ff;
   logic [HL_W-1:0] dhl_ff, ahl_ff;
   logic [LL_W-1:0] dll_ff, all_ff;
   logic [63:0] dsq_ff, asq_ff, dsum_ff, rsum_ff;
   logic ovf_ff, sat_ff;
   logic [63:0] rem_ff, lo_ff, q_ff, op_ff, res_ff, one_ff;
   logic [5:0] cnt_ff;
   logic [31:0] err_ff;
   hfrl2_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;

   logic [SQ_W-1:0] dsq_full, asq_full;
   logic [64:0] dsum_add, rsum_add, div_sh, div_sub;
   logic div_take, sqrt_take, can_load;
   logic [63:0] sqrt_trial;

   always_comb begin
      dsq_full = (SQ_W'(dhh_ff) << 48) + (SQ_W'(dhl_ff) << (LO_W + 1)) + SQ_W'(dll_ff);
      asq_full = (SQ_W'(ahh_ff) << 48) + (SQ_W'(ahl_ff) << (LO_W + 1)) + SQ_W'(all_ff);
      dsum_add = {1'b0, dsum_ff} + {1'b0, dsq_ff};
      rsum_add = {1'b0, rsum_ff} + {1'b0, asq_ff};
      // restoring divide step; the bit shifted out of rem joins the compare
      div_sh = {rem_ff, lo_ff[63]};
      div_sub = div_sh - {1'b0, rsum_ff};
      div_take = div_sh >= {1'b0, rsum_ff};
      sqrt_trial = res_ff + one_ff;
      sqrt_take = op_ff >= sqrt_trial;
   end

   assign pop = (state_ff == S_IDLE) && head.valid;
   assign can_load = !rsp_valid_ff || !rsp_stall;
   assign rsp_payload = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         dsum_ff <= '0;
         rsum_ff <= '0;
         ovf_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         // S_OUT reloads the response register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (head.valid) begin
                  cur_ff <= head.entry;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               dhh_ff <= HH_W'(cur_ff.diff_mag[LO_W +: HI_W]) * HH_W'(cur_ff.diff_mag[LO_W +: HI_W]);
               dhl_ff <= HL_W'(cur_ff.diff_mag[LO_W +: HI_W]) * HL_W'(cur_ff.diff_mag[LO_W-1:0]);
               dll_ff <= LL_W'(cur_ff.diff_mag[LO_W-1:0]) * LL_W'(cur_ff.diff_mag[LO_W-1:0]);
               ahh_ff <= HH_W'(cur_ff.ref_mag[LO_W +: HI_W]) * HH_W'(cur_ff.ref_mag[LO_W +: HI_W]);
               ahl_ff <= HL_W'(cur_ff.ref_mag[LO_W +: HI_W]) * HL_W'(cur_ff.ref_mag[LO_W-1:0]);
               all_ff <= LL_W'(cur_ff.ref_mag[LO_W-1:0]) * LL_W'(cur_ff.ref_mag[LO_W-1:0]);
               state_ff <= S_ADD;
            end
            S_ADD: begin
               dsq_ff <= dsq_full[hfrl2_pkg::SQ_SHIFT +: 64];
               asq_ff <= asq_full[hfrl2_pkg::SQ_SHIFT +: 64];
               state_ff <= S_ACC;
            end
            S_ACC: begin
               case (cur_ff.kind)
                  hfrl2_pkg::KIND_ADD: begin
                     dsum_ff <= dsum_add[64] ? '1 : dsum_add[63:0];
                     rsum_ff <= rsum_add[64] ? '1 : rsum_add[63:0];
                     if (dsum_add[64] || rsum_add[64]) begin
                        ovf_ff <= 1'b1;
                     end
                  end
                  hfrl2_pkg::KIND_BAD: ovf_ff <= 1'b1;
                  default: ;
               endcase
               state_ff <= cur_ff.last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
               if (ovf_ff) begin
                  sat_ff <= 1'b1;
                  err_ff <= '0;
                  state_ff <= S_OUT;
               end else if (rsum_ff == '0) begin
                  sat_ff <= 1'b0;
                  err_ff <= (dsum_ff == '0) ? '0 : hfrl2_pkg::ONE_Q8_24;
                  state_ff <= S_OUT;
               end else if ((dsum_ff >> 16) >= rsum_ff) begin
                  sat_ff <= 1'b1;
                  err_ff <= '0;
                  state_ff <= S_OUT;
               end else begin
                  sat_ff <= 1'b0;
                  err_ff <= '0;
                  rem_ff <= dsum_ff >> 16;
                  lo_ff <= {dsum_ff[15:0], 48'b0};
                  q_ff <= '0;
                  cnt_ff <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= div_take ? div_sub[63:0] : div_sh[63:0];
               lo_ff <= {lo_ff[62:0], 1'b0};
               q_ff <= {q_ff[62:0], div_take};
               if (cnt_ff == 6'd63) begin
                  state_ff <= S_SQRT;
                  cnt_ff <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_SQRT: begin
               if (cnt_ff == 6'd0) begin
                  // quotient is complete now; seed the root
                  op_ff <= q_ff;
                  res_ff <= '0;
                  one_ff <= 64'h4000_0000_0000_0000;
                  cnt_ff <= 6'd1;
               end else begin
                  if (sqrt_take) begin
                     op_ff <= op_ff - sqrt_trial;
                     res_ff <= (res_ff >> 1) + one_ff;
                  end else begin
                     res_ff <= res_ff >> 1;
                  end
                  one_ff <= one_ff >> 2;
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == 6'd32) begin
                     state_ff <= S_OUT;
                  end
               end
            end
            S_OUT: begin
               if (can_load) begin
                  rsp_ff.relative_error <= sat_ff ? '1 :
                                           ((cnt_ff == 6'd33) ? res_ff[31:0] : err_ff);
                  rsp_ff.within_threshold <= !sat_ff &&
                     (((cnt_ff == 6'd33) ? res_ff[31:0] : err_ff) <= threshold);
                  rsp_ff.saturated <= sat_ff;
                  rsp_valid_ff <= 1'b1;
                  dsum_ff <= '0;
                  rsum_ff <= '0;
                  ovf_ff <= 1'b0;
                  cnt_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && can_load) |=> (dsum_ff == '0 && rsum_ff == '0 && !ovf_ff))
      else $error("sums not cleared after result");

   a_sat_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.saturated) |->
         (rsp_ff.relative_error == '1 && !rsp_ff.within_threshold))
      else $error("saturated result not forced");

endmodule

// ----- src/half_float_relative_l2_error_core.sv -----
// Relative L2 error of half-precision vectors.
// Request channel (req_valid / req_stall / req_payload): one reference and
// approximation pair per request; last_pair closes the vector.
// Response channel (rsp_valid / rsp_stall / rsp_payload): one response per
// vector, given after the last pair, holding the Q8.24 error, a
// within-threshold flag and a saturation flag.
// csr_write_enable / csr_write_data set the threshold; write only when idle.
// A request enters a four-deep queue and is taken by the arithmetic sequencer,
// which handles each pair in four steps (pop, partial products, square sum,
// accumulate) and pops the next pair only after the accumulate step.
// On a last pair the sequencer adds a final check, a 64-step restoring divide
// and a 33-step bit-serial root before the response; the zero and saturated
// cases skip the divide and the root.
// Reset (synchronous) empties the queue, clears the sums and the threshold.
// While rsp_stall holds a response, the sequencer keeps accumulating the next
// vector and waits only when its own result is ready; when the queue is full
// req_stall is raised.
module half_float_relative_l2_error_core (
   input  logic               clock,
   input  logic               reset,
   input  hfrl2_pkg::req_type req_payload,
   input  logic               req_valid,
   output logic               req_stall,
   output hfrl2_pkg::rsp_type rsp_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data
);

   logic [31:0] threshold_ff;
   hfrl2_pkg::head_type head;
   logic pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_write_enable) begin
         threshold_ff <= csr_write_data;
      end
   end

   hfrl2_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .pop         (pop),
      .head        (head)
   );

   hfrl2_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .threshold   (threshold_ff),
      .rsp_payload (rsp_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall)
   );

endmodule

// ----- tb/half_float_relative_l2_error_core_test.sv -----
`timescale 1ns / 100ps

module half_float_relative_l2_error_core_test;

   localparam int SQ_DROP = 48 - hfrl2_pkg::ACC_FRAC_BITS;
   localparam int IDLE_LIMIT = 20000;

   // running sums of one vector and the expected responses they produce
   class l2_scoreboard;
      logic [63:0] diff_sum;
      logic [63:0] ref_sum;
      bit          overflow;
      logic [31:0] threshold;
      hfrl2_pkg::rsp_type pending[$];
      int          errors;
      int          vectors;

      function void clear();
         diff_sum = '0;
         ref_sum  = '0;
         overflow = 0;
         threshold = '0;
         pending.delete();
         errors = 0;
         vectors = 0;
      endfunction

      function bit decode(input logic [15:0] h, output logic signed [63:0] v);
         logic [63:0] mag;
         v = '0;
         if (h[14:10] == 5'h1f) return 0;
         if (h[14:10] == 5'd0) mag = {54'd0, h[9:0]};
         else mag = {53'd0, 1'b1, h[9:0]} << (h[14:10] - 5'd1);
         v = h[15] ? -$signed(mag) : $signed(mag);
         return 1;
      endfunction

      function logic [63:0] square_scaled(input logic [63:0] m);
         logic [127:0] p;
         p = {64'd0, m} * {64'd0, m};
         return p[SQ_DROP +: 64];
      endfunction

      function void sum_add(inout logic [63:0] acc, input logic [63:0] v);
         logic [64:0] r;
         r = {1'b0, acc} + {1'b0, v};
         if (r[64]) begin
            acc = '1;
            overflow = 1;
         end else begin
            acc = r[63:0];
         end
      endfunction

      function logic [63:0] root64(input logic [63:0] x);
         logic [63:0] r;
         logic [63:0] b;
         r = 0;
         for (int i = 31; i >= 0; i--) begin
            b = r | (64'd1 << i);
            if ({64'd0, b} * {64'd0, b} <= {64'd0, x}) r = b;
         end
         return r;
      endfunction

      function void note_request(input hfrl2_pkg::req_type rq);
         logic signed [63:0] a, b, d;
         hfrl2_pkg::rsp_type rs;
         logic [127:0] q;
         bit sat;
         if (decode(rq.reference_half, a)) begin
            if (decode(rq.approx_half, b)) begin
               d = b - a;
               sum_add(diff_sum, square_scaled(d < 0 ? -d : d));
               sum_add(ref_sum, square_scaled(a < 0 ? -a : a));
            end else begin
               overflow = 1;
            end
         end
         if (!rq.last_pair) return;
         sat = overflow;
         rs.relative_error = '0;
         if (!sat) begin
            if (ref_sum == 0) begin
               rs.relative_error = (diff_sum == 0) ? 32'd0 : hfrl2_pkg::ONE_Q8_24;
            end else if ((diff_sum >> 16) >= ref_sum) begin
               sat = 1;
            end else begin
               q = {diff_sum, 48'd0} / {64'd0, ref_sum};
               rs.relative_error = 32'(root64(q[63:0]));
            end
         end
         if (sat) rs.relative_error = '1;
         rs.within_threshold = !sat && rs.relative_error <= threshold;
         rs.saturated = sat;
         pending.push_back(rs);
         diff_sum = '0;
         ref_sum  = '0;
         overflow = 0;
      endfunction

      function void check_response(input hfrl2_pkg::rsp_type got);
         hfrl2_pkg::rsp_type want;
         if (pending.size() == 0) begin
            report_error($sformatf("unexpected response %h", got));
            return;
         end
         want = pending.pop_front();
         vectors++;
         if (got.relative_error !== want.relative_error)
            report_error($sformatf("relative_error %h, want %h",
               got.relative_error, want.relative_error));
         if (got.within_threshold !== want.within_threshold)
            report_error($sformatf("within_threshold %b, want %b",
               got.within_threshold, want.within_threshold));
         if (got.saturated !== want.saturated)
            report_error($sformatf("saturated %b, want %b",
               got.saturated, want.saturated));
      endfunction

      function void report_error(input string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $time, msg);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   hfrl2_pkg::req_type req_payload;
   logic        req_valid;
   logic        req_stall;
   hfrl2_pkg::rsp_type rsp_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   l2_scoreboard board;
   int          idle_cycles;
   bit          hold_off;
   bit          random_stall;
   int          requests_sent;

   half_float_relative_l2_error_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_payload     (req_payload),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .rsp_payload     (rsp_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   initial clock = 0;
   always #2 clock = ~clock;

   initial begin
      board = new();
      board.clear();
   end

   // response side: check and stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) board.check_response(rsp_payload);
         if (hold_off) rsp_stall <= 1;
         else if (!random_stall) rsp_stall <= 0;
         else rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function logic [15:0] random_half();
      logic [15:0] h;
      int k;
      h = 16'($urandom);
      k = $urandom_range(0, 19);
      if (k == 0) h[14:10] = 5'h1f;
      else if (k < 3) h[14:10] = 5'd0;
      else if (k < 5) h[14:10] = 5'($urandom_range(26, 30));
      else if (k != 5) h[14:10] = 5'($urandom_range(8, 20));
      return h;
   endfunction

   function logic [15:0] near_half(input logic [15:0] r);
      logic [15:0] h;
      h = r;
      h[5:0] = 6'($urandom);
      if ($urandom_range(0, 7) == 0) h[15] = ~h[15];
      return h;
   endfunction

   task automatic send_request(input logic [15:0] rf, input logic [15:0] ap,
                               input bit last);
      hfrl2_pkg::req_type rq;
      rq.reference_half = rf;
      rq.approx_half = ap;
      rq.last_pair = last;
      req_payload <= rq;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(rq);
      requests_sent++;
   endtask

   task automatic pause_sender(input int n);
      req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [31:0] v);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      board.threshold = v;
   endtask

   task automatic random_vector(input int len, input bit wellformed);
      logic [15:0] r;
      for (int i = 0; i < len; i++) begin
         r = random_half();
         if (wellformed && r[14:10] == 5'h1f) r[14:10] = 5'd15;
         send_request(r, wellformed && $urandom_range(0, 9) != 0 ? near_half(r)
                      : random_half(), i == len - 1);
         if ($urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 6));
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_payload = '0;
      csr_write_enable = 0;
      csr_write_data = '0;
      hold_off = 0;
      random_stall = 0;
      requests_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero vector, zero reference with error, extremes, specials
      send_request(16'h0000, 16'h0000, 1);
      send_request(16'h0000, 16'h3c00, 1);
      send_request(16'h8000, 16'h0001, 1);
      send_request(16'h3c00, 16'h3c00, 1);
      send_request(16'h3c00, 16'h3e00, 1);
      send_request(16'h0001, 16'h7bff, 1);
      send_request(16'h7bff, 16'hfbff, 0);
      send_request(16'hfbff, 16'h7bff, 1);
      send_request(16'h7c00, 16'h3c00, 0);
      send_request(16'h4000, 16'h4001, 1);
      send_request(16'h7e01, 16'h0000, 1);
      send_request(16'h3c00, 16'h7c00, 1);
      send_request(16'h3c00, 16'hfe00, 0);
      send_request(16'h3c00, 16'h3c00, 1);
      send_request(16'h03ff, 16'h83ff, 1);
      send_request(16'h5555, 16'haaaa, 1);
      send_request(16'hffff, 16'hffff, 1);
      // large sums: repeated maximal pairs
      for (int i = 0; i < 6; i++) send_request(16'h7bff, 16'hfbff, i == 5);

      write_threshold(32'hffff_ffff);
      send_request(16'h3c00, 16'h3c01, 1);
      send_request(16'h3c00, 16'h7bff, 1);
      write_threshold(32'h0000_4000);

      random_stall = 1;
      while (requests_sent < 1350) begin
         if (requests_sent > 600 && requests_sent < 640 && !hold_off) begin
            // long receiver hold-off while requests keep coming
            fork
               begin
                  hold_off = 1;
                  repeat (600) @(posedge clock);
                  hold_off = 0;
               end
            join_none
            random_vector(30, 1);
            random_vector(2, 1);
         end else if ($urandom_range(0, 9) == 0) begin
            random_vector($urandom_range(1, 6), 0);
         end else begin
            random_vector($urandom_range(1, 16), 1);
         end
         if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 20));
         if ($urandom_range(0, 60) == 0) drain();
         if ($urandom_range(0, 150) == 0) begin
            case ($urandom_range(0, 2))
               0: write_threshold(32'd0);
               1: write_threshold(32'hffff_ffff);
               default: write_threshold($urandom_range(0, 32'h0200_0000));
            endcase
         end
      end

      drain();
      $display("Covered %0d requests in %0d vectors with specials, saturation,",
               requests_sent, board.vectors);
      $display("threshold extremes, bursty input and long output stalls.");
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
